[rtl/tbpb_pkg.sv]
`timescale 1ns / 1ps
package tbpb_pkg;
   localparam int VideoDepth = 24576;
   localparam int RomDepth = 16384;
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_BLIT = 2'd2;
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam logic [1:0] ROUTE_VV = 2'd0;
   localparam logic [1:0] ROUTE_RV = 2'd1;
   localparam logic [1:0] ROUTE_EV = 2'd2;
   localparam logic [1:0] ROUTE_VE = 2'd3;
   localparam logic [1:0] REG_WIDE = 2'd0;
   localparam logic [1:0] REG_SPAGE = 2'd1;
   localparam logic [1:0] REG_DPAGE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  control;
      logic [7:0]  palette_map;
      logic [7:0]  src_x;
      logic [7:0]  src_y;
      logic [7:0]  dst_x;
      logic [7:0]  dst_y;
      logic [7:0]  width_x;
      logic [7:0]  width_y;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       done_res;
   } rsp_type;

   typedef struct packed {
      logic wide_lines;
      logic source_page;
      logic dest_page;
   } cfg_type;

   // Pixel x counts from the most significant pair of the byte.
   function automatic logic [1:0] pick_pixel(logic [7:0] b, logic [1:0] pos);
      logic [7:0] s;
      s = b >> (3'd6 - {pos, 1'b0});
      return s[1:0];
   endfunction

   function automatic logic [7:0] place_pixel(logic [7:0] b, logic [1:0] pos,
                                              logic [1:0] pix);
      logic [2:0] sh;
      sh = 3'd6 - {pos, 1'b0};
      return (b & ~(8'd3 << sh)) | ({6'd0, pix} << sh);
   endfunction
endpackage

[rtl/tbpb_if.sv]
`timescale 1ns / 1ps
interface tbpb_req_if;
   logic valid;
   logic ready;
   tbpb_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tbpb_rsp_if;
   logic valid;
   logic ready;
   tbpb_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/two_bit_pixel_blit_dma_core.sv]
`timescale 1ns / 1ps
// Channel | Direction | Contents
// req     | in        | cmd, addr, wdata, control, palette_map, src/dst x/y, widths
// rsp     | out       | rdata, done_res
// csr     | in/out    | wide_lines, source_page, dest_page
// A write, a disabled blit or an unknown command goes from accept straight to the result.
// A read goes from accept through a registered RAM read to the result.
// An enabled blit steps through every pixel of the rectangle: each pixel reads its
// source byte, then its destination byte, then writes back, as the video RAM has one
// read port. Reset is synchronous and clears control state only; memories are not cleared.
// A result waits in an output register while rsp.ready is low; no item is taken meanwhile.
module two_bit_pixel_blit_dma_core (
   input  logic        clock,
   input  logic        reset,
   tbpb_req_if.sink    req,
   tbpb_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_PIXR = 3'd2;
   localparam logic [2:0] ST_PIXW = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;
   localparam logic [2:0] ST_PIXD = 3'd5;

   tbpb_pkg::cfg_type cfg;
   tbpb_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg
   );

   logic [2:0] st_ff, st_in;
   logic [7:0] rdata_ff, rdata_in;
   logic done_ff, done_in;
   logic rdsrc_ff, rdsrc_in;      // read came from the ROM window
   logic [7:0] ctl_ff, ctl_in, pal_ff, pal_in;
   logic [7:0] sx_ff, sx_in, dx_ff, dx_in, sx0_ff, sx0_in, dx0_ff, dx0_in;
   logic [7:0] wx_ff, wx_in, xc_ff, xc_in, yc_ff, yc_in;
   logic [15:0] sline_ff, sline_in, dline_ff, dline_in;
   logic [15:0] scur_ff, scur_in, dcur_ff, dcur_in;
   logic [6:0] spitch_ff, spitch_in, dpitch_ff, dpitch_in;
   logic [14:0] sbase_ff, sbase_in, dbase_ff, dbase_in;
   logic [7:0] src_ff, src_in;    // source byte of the current pixel

   // One RAM for the video store and one for the ROM window.
   logic v_we, r_we;
   logic [14:0] v_waddr, v_raddr;
   logic [13:0] r_waddr, r_raddr;
   logic [7:0] v_wdata, r_wdata, v_rdata, r_rdata;

   tbpb_ram #(.Width(8), .Depth(tbpb_pkg::VideoDepth)) u_vram (
      .clock, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
      .raddr(v_raddr), .rdata(v_rdata));
   tbpb_ram #(.Width(8), .Depth(tbpb_pkg::RomDepth)) u_rom (
      .clock, .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(r_raddr), .rdata(r_rdata));

   logic acc;
   tbpb_pkg::req_type d;
   assign d = req.data;
   assign req.ready = (st_ff == ST_IDLE);
   assign acc = req.valid && req.ready;
   assign rsp.valid = (st_ff == ST_OUT);
   assign rsp.data.rdata = rdata_ff;
   assign rsp.data.done_res = done_ff;

   // Pixel arithmetic for the current step.
   logic [1:0] route;
   logic from_rom, ovw, dec;
   logic [14:0] sa, da;
   logic [13:0] sm;
   logic [12:0] dm;
   logic [1:0] spix, dpix, pix, opix;
   logic [7:0] sbyte;
   logic [15:0] sum_d;
   logic [6:0] vpitch, sp0, dp0;
   logic [14:0] sb0, db0;
   logic [15:0] sline0, dline0;

   assign route = ctl_ff[2:1];
   assign from_rom = (route == tbpb_pkg::ROUTE_RV);
   assign ovw = ctl_ff[0];
   assign dec = ctl_ff[3];
   assign sm = from_rom ? scur_ff[13:0] : {1'b0, scur_ff[12:0]};
   assign dm = dcur_ff[12:0];
   // Base plus a 13-bit offset stays below the store depth.
   assign sa = sbase_ff + {1'b0, sm};
   assign sum_d = {1'b0, dbase_ff} + {3'd0, dm};
   assign da = sum_d[14:0];
   assign sbyte = src_ff;
   assign spix = tbpb_pkg::pick_pixel(sbyte, sx_ff[1:0]);
   assign dpix = tbpb_pkg::pick_pixel(v_rdata, dx_ff[1:0]);
   assign pix = (!ovw && spix == 2'd0) ? dpix : spix;
   always_comb begin
      case (pix)
         2'd0: opix = pal_ff[1:0];
         2'd1: opix = pal_ff[3:2];
         2'd2: opix = pal_ff[5:4];
         default: opix = pal_ff[7:6];
      endcase
   end

   // Start geometry from the accepted item.
   always_comb begin
      vpitch = cfg.wide_lines ? 7'd50 : 7'd40;
      sp0 = vpitch;
      dp0 = vpitch;
      sb0 = cfg.source_page ? 15'h2000 : 15'h0;
      db0 = cfg.dest_page ? 15'h2000 : 15'h0;
      case (d.control[2:1])
         tbpb_pkg::ROUTE_RV: sp0 = 7'd64;
         tbpb_pkg::ROUTE_EV: begin
            sp0 = 7'd64;
            sb0 = 15'h4000;
         end
         tbpb_pkg::ROUTE_VE: begin
            dp0 = 7'd64;
            db0 = 15'h4000;
         end
         default: ;
      endcase
      if (d.control[2:1] == tbpb_pkg::ROUTE_RV) sb0 = 15'h0;
      sline0 = 16'(sp0 * d.src_y) + {10'd0, d.src_x[7:2]};
      dline0 = 16'(dp0 * d.dst_y) + {10'd0, d.dst_x[7:2]};
   end

   // Sequencer and memory port control.
   always_comb begin
      st_in = st_ff;
      rdata_in = rdata_ff;
      done_in = done_ff;
      rdsrc_in = rdsrc_ff;
      ctl_in = ctl_ff; pal_in = pal_ff;
      sx_in = sx_ff; dx_in = dx_ff; sx0_in = sx0_ff; dx0_in = dx0_ff;
      wx_in = wx_ff; xc_in = xc_ff; yc_in = yc_ff;
      sline_in = sline_ff; dline_in = dline_ff;
      scur_in = scur_ff; dcur_in = dcur_ff;
      spitch_in = spitch_ff; dpitch_in = dpitch_ff;
      sbase_in = sbase_ff; dbase_in = dbase_ff;
      src_in = src_ff;
      v_we = 1'b0; r_we = 1'b0;
      v_waddr = d.addr[14:0]; v_wdata = d.wdata;
      r_waddr = 14'(d.addr - 16'(tbpb_pkg::VideoDepth)); r_wdata = d.wdata;
      v_raddr = d.addr[14:0];
      r_raddr = r_waddr;
      unique case (st_ff)
         ST_IDLE: if (acc) begin
            rdata_in = '0;
            done_in = 1'b0;
            case (d.cmd)
               tbpb_pkg::CMD_WRITE: begin
                  if (d.addr < 16'(tbpb_pkg::VideoDepth)) v_we = 1'b1;
                  else if (d.addr < 16'(tbpb_pkg::VideoDepth + tbpb_pkg::RomDepth))
                     r_we = 1'b1;
                  st_in = ST_OUT;
               end
               tbpb_pkg::CMD_READ: begin
                  st_in = ST_READ;
                  rdsrc_in = ~(d.addr < 16'(tbpb_pkg::VideoDepth));
                  ctl_in = {7'd0,
                     d.addr < 16'(tbpb_pkg::VideoDepth + tbpb_pkg::RomDepth)};
               end
               tbpb_pkg::CMD_BLIT: begin
                  if (d.control[7]) begin
                     ctl_in = d.control; pal_in = d.palette_map;
                     sx_in = d.src_x; sx0_in = d.src_x;
                     dx_in = d.dst_x; dx0_in = d.dst_x;
                     wx_in = d.width_x; xc_in = '0; yc_in = d.width_y;
                     sline_in = sline0; dline_in = dline0;
                     scur_in = sline0; dcur_in = dline0;
                     spitch_in = sp0; dpitch_in = dp0;
                     sbase_in = sb0; dbase_in = db0;
                     st_in = ST_PIXR;
                  end else st_in = ST_OUT;
               end
               default: st_in = ST_OUT;
            endcase
         end
         ST_READ: begin
            if (ctl_ff[0]) rdata_in = rdsrc_ff ? r_rdata : v_rdata;
            st_in = ST_OUT;
         end
         ST_PIXR: begin
            // Issue the read of the source byte.
            v_raddr = sa;
            r_raddr = scur_ff[13:0];
            st_in = ST_PIXD;
         end
         ST_PIXD: begin
            // Hold the source byte and issue the read of the destination byte.
            src_in = from_rom ? r_rdata : v_rdata;
            v_raddr = da;
            st_in = ST_PIXW;
         end
         ST_PIXW: begin
            v_we = 1'b1;
            v_waddr = da;
            v_wdata = tbpb_pkg::place_pixel(v_rdata, dx_ff[1:0], opix);
            if (dec) begin
               sx_in = sx_ff - 8'd1;
               if (sx_ff[1:0] == 2'd0) scur_in = scur_ff - 16'd1;
            end else begin
               sx_in = sx_ff + 8'd1;
               if (sx_ff[1:0] == 2'd3) scur_in = scur_ff + 16'd1;
            end
            dx_in = dx_ff + 8'd1;
            if (dx_ff[1:0] == 2'd3) dcur_in = dcur_ff + 16'd1;
            xc_in = xc_ff + 8'd1;
            st_in = ST_PIXR;
            if (xc_ff == wx_ff) begin
               xc_in = '0;
               sx_in = sx0_ff; dx_in = dx0_ff;
               sline_in = sline_ff + {9'd0, spitch_ff};
               dline_in = dline_ff + {9'd0, dpitch_ff};
               scur_in = sline_ff + {9'd0, spitch_ff};
               dcur_in = dline_ff + {9'd0, dpitch_ff};
               yc_in = yc_ff - 8'd1;
               if (yc_ff == 8'd0) begin
                  done_in = 1'b1;
                  st_in = ST_OUT;
               end
            end
         end
         ST_OUT: if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      rdata_ff <= rdata_in; done_ff <= done_in; rdsrc_ff <= rdsrc_in;
      ctl_ff <= ctl_in; pal_ff <= pal_in;
      sx_ff <= sx_in; dx_ff <= dx_in; sx0_ff <= sx0_in; dx0_ff <= dx0_in;
      wx_ff <= wx_in; xc_ff <= xc_in; yc_ff <= yc_in;
      sline_ff <= sline_in; dline_ff <= dline_in;
      scur_ff <= scur_in; dcur_ff <= dcur_in;
      spitch_ff <= spitch_in; dpitch_ff <= dpitch_in;
      sbase_ff <= sbase_in; dbase_ff <= dbase_in;
      src_ff <= src_in;
   end

   // A pixel write always follows its destination read cycle.
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_PIXW |-> $past(st_ff) == ST_PIXD) else $error("pixel write out of order");
   // No new item while a result waits.
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("item taken while result pending");
   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.data)) else $error("result changed");
endmodule

[rtl/tbpb_ram.sv]
`timescale 1ns / 1ps
module tbpb_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

[rtl/tbpb_csr.sv]
`timescale 1ns / 1ps
module tbpb_csr (
   input  logic          clock,
   input  logic          reset,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [3:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready,
   output tbpb_pkg::cfg_type cfg
);
   tbpb_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0] idx;

   assign idx = paddr[3:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   // Register writes at the access phase.
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         unique case (idx)
            tbpb_pkg::REG_WIDE:  cfg_in.wide_lines = pwdata[0];
            tbpb_pkg::REG_SPAGE: cfg_in.source_page = pwdata[0];
            tbpb_pkg::REG_DPAGE: cfg_in.dest_page = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   // Read back.
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'd0) begin
         unique case (idx)
            tbpb_pkg::REG_WIDE:  prdata[0] = cfg_ff.wide_lines;
            tbpb_pkg::REG_SPAGE: prdata[0] = cfg_ff.source_page;
            tbpb_pkg::REG_DPAGE: prdata[0] = cfg_ff.dest_page;
            default: ;
         endcase
      end
   end
endmodule

[test/tbpb_checker.sv]
`timescale 1ns / 1ps
module tbpb_checker (
   input  logic        clock,
   input  logic        reset,
   tbpb_req_if         req,
   tbpb_rsp_if         rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          errors,
   output int          pending
);
   // Shadow copies of the memories and the registers.
   logic [7:0]        vid_mirror [tbpb_pkg::VideoDepth];
   logic [7:0]        rom_mirror [tbpb_pkg::RomDepth];
   tbpb_pkg::cfg_type cfg_mirror;
   tbpb_pkg::rsp_type rsp_expected [$];

   function automatic logic [1:0] get_pair(logic [7:0] b, logic [7:0] xpos);
      case (xpos[1:0])
         2'd0: return b[7:6];
         2'd1: return b[5:4];
         2'd2: return b[3:2];
         default: return b[1:0];
      endcase
   endfunction

   function automatic logic [7:0] put_pair(logic [7:0] b, logic [7:0] xpos,
                                           logic [1:0] p);
      logic [7:0] r;
      r = b;
      case (xpos[1:0])
         2'd0: r[7:6] = p;
         2'd1: r[5:4] = p;
         2'd2: r[3:2] = p;
         default: r[1:0] = p;
      endcase
      return r;
   endfunction

   // Copies the rectangle pixel by pixel in raster order, as the block does.
   task automatic apply_blit(tbpb_pkg::req_type it);
      int unsigned vpitch, spitch, dpitch, smask, dmask, sbase, dbase;
      int unsigned sline, dline, scur, dcur, sa, da, y, x;
      logic [7:0]  sxc, dxc, sbyte;
      logic [1:0]  pix, route;
      bit          from_rom;
      route = it.control[2:1];
      vpitch = cfg_mirror.wide_lines ? 50 : 40;
      spitch = vpitch;
      dpitch = vpitch;
      smask = 'h1FFF;
      dmask = 'h1FFF;
      sbase = cfg_mirror.source_page ? 'h2000 : 0;
      dbase = cfg_mirror.dest_page ? 'h2000 : 0;
      from_rom = 0;
      case (route)
         tbpb_pkg::ROUTE_RV: begin
            spitch = 64;
            smask = 'h3FFF;
            from_rom = 1;
         end
         tbpb_pkg::ROUTE_EV: begin
            spitch = 64;
            sbase = 'h4000;
         end
         tbpb_pkg::ROUTE_VE: begin
            dpitch = 64;
            dbase = 'h4000;
         end
         default: ;
      endcase
      sline = spitch * it.src_y + (it.src_x >> 2);
      dline = dpitch * it.dst_y + (it.dst_x >> 2);
      for (y = 0; y <= it.width_y; y++) begin
         scur = sline;
         dcur = dline;
         sxc = it.src_x;
         dxc = it.dst_x;
         for (x = 0; x <= it.width_x; x++) begin
            sa = scur & smask;
            da = (dbase + (dcur & dmask)) % tbpb_pkg::VideoDepth;
            sbyte = from_rom ? rom_mirror[sa & 'h3FFF]
                             : vid_mirror[(sbase + sa) % tbpb_pkg::VideoDepth];
            pix = get_pair(sbyte, sxc);
            // Transparent pixel: the destination pixel shows through.
            if (!it.control[0] && pix == 2'd0) pix = get_pair(vid_mirror[da], dxc);
            pix = it.palette_map[2 * pix +: 2];
            vid_mirror[da] = put_pair(vid_mirror[da], dxc, pix);
            if (it.control[3]) begin
               sxc = sxc - 8'd1;
               if (sxc[1:0] == 2'd3) scur = scur - 1;
            end else begin
               sxc = sxc + 8'd1;
               if (sxc[1:0] == 2'd0) scur = scur + 1;
            end
            dxc = dxc + 8'd1;
            if (dxc[1:0] == 2'd0) dcur = dcur + 1;
         end
         sline += spitch;
         dline += dpitch;
      end
   endtask

   task automatic predict_response(tbpb_pkg::req_type it);
      tbpb_pkg::rsp_type r;
      r = '0;
      case (it.cmd)
         tbpb_pkg::CMD_WRITE: begin
            if (it.addr < tbpb_pkg::VideoDepth) vid_mirror[it.addr] = it.wdata;
            else if (it.addr < tbpb_pkg::VideoDepth + tbpb_pkg::RomDepth)
               rom_mirror[it.addr - tbpb_pkg::VideoDepth] = it.wdata;
         end
         tbpb_pkg::CMD_READ: begin
            if (it.addr < tbpb_pkg::VideoDepth) r.rdata = vid_mirror[it.addr];
            else if (it.addr < tbpb_pkg::VideoDepth + tbpb_pkg::RomDepth)
               r.rdata = rom_mirror[it.addr - tbpb_pkg::VideoDepth];
         end
         tbpb_pkg::CMD_BLIT: begin
            if (it.control[7]) begin
               apply_blit(it);
               r.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      rsp_expected.push_back(r);
   endtask

   assign pending = rsp_expected.size();

   // Register writes, accepted items and results, all seen at the clock edge.
   always @(posedge clock) begin
      if (reset) begin
         cfg_mirror <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               tbpb_pkg::REG_WIDE: cfg_mirror.wide_lines <= csr_pwdata[0];
               tbpb_pkg::REG_SPAGE: cfg_mirror.source_page <= csr_pwdata[0];
               tbpb_pkg::REG_DPAGE: cfg_mirror.dest_page <= csr_pwdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) predict_response(req.data);
         if (rsp.valid && rsp.ready) begin
            if (rsp_expected.size() == 0) begin
               $error("result item with no expectation: rdata %0h done_res %0b",
                      rsp.data.rdata, rsp.data.done_res);
               errors++;
            end else begin
               if (rsp.data.rdata !== rsp_expected[0].rdata) begin
                  $error("rdata: expected %0h, actual %0h", rsp_expected[0].rdata,
                         rsp.data.rdata);
                  errors++;
               end
               if (rsp.data.done_res !== rsp_expected[0].done_res) begin
                  $error("done_res: expected %0b, actual %0b", rsp_expected[0].done_res,
                         rsp.data.done_res);
                  errors++;
               end
               void'(rsp_expected.pop_front());
            end
         end
      end
   end

   initial errors = 0;
endmodule

[test/two_bit_pixel_blit_dma_core_tb.sv]
`timescale 1ns / 1ps
module two_bit_pixel_blit_dma_core_tb;
   localparam int StallLimit = 400000;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   bit          calm;
   int          rsp_stall;
   int          quiet_cycles;
   int          items_sent;
   int          blits_sent;

   tbpb_req_if req ();
   tbpb_rsp_if rsp ();

   two_bit_pixel_blit_dma_core uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   tbpb_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver stalls in random bursts unless the run is in its calm part.
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 14) == 0) begin
         rsp_stall <= $urandom_range(1, 17) - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Watchdog: too long without any item moving ends the run.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("timeout with %0d results outstanding", pending);
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, bit value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Withdraws the input and waits until every expected result has come.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(bit wide, bit spage, bit dpage);
      drain();
      csr_write(tbpb_pkg::REG_WIDE, wide);
      csr_write(tbpb_pkg::REG_SPAGE, spage);
      csr_write(tbpb_pkg::REG_DPAGE, dpage);
   endtask

   // Presents one item, sometimes after a random gap, and holds it until taken.
   task automatic issue(tbpb_pkg::req_type it);
      int gap;
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 17);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      if (it.cmd == tbpb_pkg::CMD_BLIT) blits_sent++;
   endtask

   // Byte address in the corner of a store that the run keeps written:
   // areas are page 0 and page 1 at both VRAM pitches, extended RAM and ROM.
   function automatic logic [15:0] window_addr(int area, int line, int col);
      int base;
      int pitch;
      if (area < 2) base = 0;
      else if (area < 4) base = 'h2000;
      else if (area == 4) base = 'h4000;
      else base = tbpb_pkg::VideoDepth;
      if (area >= 4) pitch = 64;
      else pitch = (area % 2 == 1) ? 50 : 40;
      return 16'(base + pitch * line + col);
   endfunction

   function automatic tbpb_pkg::req_type noise_item();
      tbpb_pkg::req_type it;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      it = raw[$bits(tbpb_pkg::req_type)-1:0];
      return it;
   endfunction

   function automatic tbpb_pkg::req_type byte_item(logic [1:0] cmd, logic [15:0] addr,
                                                   logic [7:0] data);
      tbpb_pkg::req_type it;
      it = noise_item();
      it.cmd = cmd;
      it.addr = addr;
      it.wdata = data;
      return it;
   endfunction

   // Blits stay inside the written corner: widths up to 16 by 3 pixels.
   function automatic tbpb_pkg::req_type blit_item(logic [7:0] ctl, logic [7:0] wx,
                                                   logic [7:0] wy);
      tbpb_pkg::req_type it;
      it = noise_item();
      it.cmd = tbpb_pkg::CMD_BLIT;
      it.control = ctl;
      it.width_x = wx;
      it.width_y = wy;
      it.src_y = 8'($urandom_range(0, 1));
      it.dst_y = 8'($urandom_range(0, 1));
      it.dst_x = 8'($urandom_range(0, 15));
      if (ctl[3]) it.src_x = wx + 8'($urandom_range(0, 15));
      else it.src_x = 8'($urandom_range(0, 15));
      return it;
   endfunction

   function automatic tbpb_pkg::req_type random_item();
      tbpb_pkg::req_type it;
      int pick;
      logic [7:0] ctl;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         ctl = 8'($urandom_range(0, 255)) | (($urandom_range(0, 7) != 0) ? 8'h80 : 8'h00);
         it = blit_item(ctl, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 2)));
      end else if (pick < 70) begin
         if ($urandom_range(0, 4) == 0)
            it = byte_item(tbpb_pkg::CMD_WRITE, 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)));
         else
            it = byte_item(tbpb_pkg::CMD_WRITE, window_addr($urandom_range(0, 5),
                           $urandom_range(0, 3), $urandom_range(0, 7)),
                           8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
         if ($urandom_range(0, 9) == 0)
            it = byte_item(tbpb_pkg::CMD_READ, 16'($urandom_range(40960, 65535)), 8'd0);
         else
            it = byte_item(tbpb_pkg::CMD_READ, window_addr($urandom_range(0, 5),
                           $urandom_range(0, 3), $urandom_range(0, 7)), 8'd0);
      end else begin
         it = noise_item();
         it.cmd = tbpb_pkg::CMD_NOP;
      end
      return it;
   endfunction

   initial begin
      tbpb_pkg::req_type it;
      int i;
      int p;
      int a;
      int r;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      calm = 1'b1;
      rsp_stall = 0;
      quiet_cycles = 0;
      items_sent = 0;
      blits_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_config(1'b0, 1'b0, 1'b0);

      // Fill the corner of every area that blits and reads touch.
      for (a = 0; a < 6; a++)
         for (r = 0; r < 4; r++)
            for (i = 0; i < 8; i++)
               issue(byte_item(tbpb_pkg::CMD_WRITE, window_addr(a, r, i),
                               8'($urandom_range(0, 255))));
      calm = 1'b0;

      // Directed items: address extremes, odd commands, each route and mode.
      issue(byte_item(tbpb_pkg::CMD_WRITE, 16'd0, 8'hFF));
      issue(byte_item(tbpb_pkg::CMD_READ, 16'd0, 8'h00));
      issue(byte_item(tbpb_pkg::CMD_WRITE, 16'd24575, 8'h00));
      issue(byte_item(tbpb_pkg::CMD_READ, 16'd24575, 8'h00));
      issue(byte_item(tbpb_pkg::CMD_WRITE, 16'd40959, 8'hA5));
      issue(byte_item(tbpb_pkg::CMD_READ, 16'd40959, 8'h00));
      issue(byte_item(tbpb_pkg::CMD_READ, 16'd24576, 8'h00));
      issue(byte_item(tbpb_pkg::CMD_WRITE, 16'hFFFF, 8'h5A));
      issue(byte_item(tbpb_pkg::CMD_READ, 16'hFFFF, 8'h00));
      issue(byte_item(tbpb_pkg::CMD_READ, 16'd40960, 8'h00));
      it = noise_item();
      it.cmd = tbpb_pkg::CMD_NOP;
      issue(it);
      issue(blit_item(8'h7F, 8'd3, 8'd2));
      for (p = 0; p < 4; p++) begin
         issue(blit_item(8'(8'h80 | (p << 1)), 8'd5, 8'd2));
         issue(blit_item(8'(8'h89 | (p << 1)), 8'd6, 8'd1));
      end
      it = blit_item(8'h80, 8'd12, 8'd2);
      it.src_x = 8'd0;
      it.src_y = 8'd0;
      it.dst_x = 8'd2;
      it.dst_y = 8'd1;
      issue(it);
      it = blit_item(8'hFF, 8'd15, 8'd2);
      it.palette_map = 8'hFF;
      issue(it);
      it = blit_item(8'h80, 8'd0, 8'd2);
      it.palette_map = 8'h00;
      issue(it);
      issue(blit_item(8'h83, 8'd15, 8'd2));

      // Random phases over every register setting, then a few random ones.
      for (p = 0; p < 11; p++) begin
         if (p < 8) set_config(p[0], p[1], p[2]);
         else set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         if (p == 10) calm = 1'b1;
         for (i = 0; i < 36; i++) begin
            if (p == 4 && i == 18) drain();
            issue(random_item());
         end
      end
      drain();

      repeat (20) @(posedge clock);
      $display("Sent %0d items, %0d of them blits, across every register setting,",
               items_sent, blits_sent);
      $display("over a written corner of each store with random stalls on both channels.");
      if (errors == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
